>>> rtl/vat_pkg.sv
// ----------------------------------------------------------------------------
// vat_pkg: shared types and constants
// request codes, register indexes, fixed-point constants and iteration steps
// ----------------------------------------------------------------------------
package vat_pkg;

    // wide accumulator width: holds cofactor times component sums with margin
    localparam int VW       = 100;
    // chunking of the leading-one search
    localparam int CW       = 10;
    localparam int NCH      = VW / CW;
    // square root: result bits and stages at two bits per stage
    localparam int RT_BITS  = 31;
    localparam int RT_N     = (RT_BITS + 1) / 2;
    // quotient bits of the normalizing divide, two per stage
    localparam int QB       = 17;
    localparam int DV_N     = (QB + 1) / 2;

    typedef logic signed [VW-1:0] wide_t;
    typedef logic signed [64:0]   cof_t;

    typedef enum logic [1:0] {
        REQ_POS = 2'd0,
        REQ_DIR = 2'd1,
        REQ_NRM = 2'd2,
        REQ_RSV = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        REG_R0_XY = 3'd0,
        REG_R0_ZT = 3'd1,
        REG_R1_XY = 3'd2,
        REG_R1_ZT = 3'd3,
        REG_R2_XY = 3'd4,
        REG_R2_ZT = 3'd5
    } reg_idx_t;

    localparam int          NUM_REGS   = 6;
    localparam logic [63:0] RST_ROW0XY = 64'h0001_0000_0000_0000;
    localparam logic [63:0] RST_ROW1XY = 64'h0000_0000_0001_0000;
    localparam logic [63:0] RST_ROW2ZT = 64'h0001_0000_0000_0000;
    localparam logic [63:0] RST_ZERO   = 64'h0;

    localparam logic [31:0]   Q_ONE      = 32'h0001_0000;
    localparam logic [VW-1:0] SING_LIMIT = VW'(64'd28147497671);
    localparam logic [VW-1:0] DIR_THR    = VW'(64'h1_0000_0000);
    localparam logic [13:0]   LEN_SCALE  = 14'd10000;
    localparam logic [VW-1:0] RND_HALF   = VW'(32'h8000);
    localparam logic [31:0]   SAT_POS    = 32'h7FFF_FFFF;
    localparam logic [31:0]   SAT_NEG    = 32'h8000_0000;

    // reload value of the settle counter that holds off input after a config write
    localparam logic [2:0]    SETTLE     = 3'd6;

    typedef struct packed {
        logic [63:0]        rem;
        logic [RT_BITS-1:0] root;
    } rt_t;

    typedef struct packed {
        logic [47:0]   rem;
        logic [QB-1:0] quo;
    } dv_t;

    // one digit of the square root: decides root bit k
    function automatic rt_t rt_step(rt_t x, int k);
        logic [63:0] trial;
        rt_t         y;
        y     = x;
        trial = (64'(x.root) << (k + 1)) + (64'd1 << (2 * k));
        if (x.rem >= trial) begin
            y.rem  = x.rem - trial;
            y.root = x.root | (RT_BITS'(1) << k);
        end
        return y;
    endfunction

    // one digit of restoring division: decides quotient bit k
    function automatic dv_t dv_step(dv_t x, logic [RT_BITS-1:0] len, int k);
        logic [47:0] d;
        dv_t         y;
        y = x;
        d = 48'(len) << k;
        if (x.rem >= d) begin
            y.rem = x.rem - d;
            y.quo = x.quo | (QB'(1) << k);
        end
        return y;
    endfunction

endpackage

>>> rtl/vertex_attribute_transform.sv
// ----------------------------------------------------------------------------
// vertex_attribute_transform
// 3x4 affine transform of a q16.16 vector: position, normalized direction, or
// normal through the inverse transpose, with fallback flag and saturation
// ----------------------------------------------------------------------------
// one vector per cycle unless stalled; the pipeline is stalled as a whole
// while a result waits on the output. the depth comes mostly from the square
// root (16 stages, up to two root bits each) and the normalizing divide (9
// stages, up to two quotient bits each). after reset and after any
// configuration write, s_ready stays low while the cofactors, determinant and
// singular flag are recomputed in a small side pipeline. the user must write
// configuration only while no transaction is in flight; the block does not enforce it.
module vertex_attribute_transform (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration write port
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_wr_data,
    // input vector
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_req_type,
    input  logic signed [31:0] s_in_x,
    input  logic signed [31:0] s_in_y,
    input  logic signed [31:0] s_in_z,
    // result vector
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_out_x,
    output logic signed [31:0] m_out_y,
    output logic signed [31:0] m_out_z,
    output logic               m_fallback_used
);

    // stage map
    localparam int S_IN   = 1;                   // input capture
    localparam int S_MUL  = 2;                   // coefficient products
    localparam int S_CMB  = 3;                   // partial product merge
    localparam int S_SUM  = 4;                   // row sums
    localparam int S_ABS  = 5;                   // magnitudes, position rounding
    localparam int S_CHK  = 6;                   // per-chunk leading one
    localparam int S_LZ   = 7;                   // leading one position
    localparam int S_SHF  = 8;                   // scale to 30 bits
    localparam int S_SQ   = 9;                   // squares
    localparam int S_SSUM = 10;                  // sum of squares
    localparam int S_RT0  = 11;                  // first root stage
    localparam int S_LEN  = S_RT0 + vat_pkg::RT_N;  // length scaling, dividend
    localparam int S_DV0  = S_LEN + 1;           // first divide stage
    localparam int S_OUT  = S_DV0 + vat_pkg::DV_N;  // output register

    logic ce;
    logic accept;

    // ------------------------------------------------------------------
    // configuration registers and derived matrix values
    // ------------------------------------------------------------------
    logic [63:0]        cfg_reg [vat_pkg::NUM_REGS];
    logic [2:0]         settle_reg;
    logic signed [31:0] mat [3][3];
    logic signed [31:0] tr  [3];

    logic signed [63:0]       cpa_reg  [3][3];
    logic signed [63:0]       cpb_reg  [3][3];
    vat_pkg::cof_t            cof_reg  [3][3];
    vat_pkg::cof_t            ncof_reg [3][3];
    logic signed [64:0]       dhi_reg  [3];
    logic signed [64:0]       dlo_reg  [3];
    vat_pkg::wide_t           dpart_reg [3];
    vat_pkg::wide_t           det_reg;
    logic [vat_pkg::VW-1:0]   dabs_reg;
    logic                     sing_reg;
    logic [vat_pkg::VW-1:0]   det_abs;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg[vat_pkg::REG_R0_XY] <= vat_pkg::RST_ROW0XY;
            cfg_reg[vat_pkg::REG_R0_ZT] <= vat_pkg::RST_ZERO;
            cfg_reg[vat_pkg::REG_R1_XY] <= vat_pkg::RST_ROW1XY;
            cfg_reg[vat_pkg::REG_R1_ZT] <= vat_pkg::RST_ZERO;
            cfg_reg[vat_pkg::REG_R2_XY] <= vat_pkg::RST_ZERO;
            cfg_reg[vat_pkg::REG_R2_ZT] <= vat_pkg::RST_ROW2ZT;
            settle_reg                  <= vat_pkg::SETTLE;
        end else if (cfg_wr_en) begin
            // writes beyond the register list are dropped
            if (32'(cfg_index) < vat_pkg::NUM_REGS) begin
                cfg_reg[cfg_index] <= cfg_wr_data;
            end
            settle_reg <= vat_pkg::SETTLE;
        end else if (settle_reg != 3'd0) begin
            settle_reg <= settle_reg - 3'd1;
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            mat[r][0] = cfg_reg[2*r][63:32];
            mat[r][1] = cfg_reg[2*r][31:0];
            mat[r][2] = cfg_reg[2*r+1][63:32];
            tr[r]     = cfg_reg[2*r+1][31:0];
        end
        det_abs = det_reg[vat_pkg::VW-1] ? vat_pkg::VW'(-det_reg) : vat_pkg::VW'(det_reg);
    end

    // side pipeline: cofactors, determinant, sign-folded cofactors
    always_ff @(posedge aclk) begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                cpa_reg[i][j]  <= mat[(i+1)%3][(j+1)%3] * mat[(i+2)%3][(j+2)%3];
                cpb_reg[i][j]  <= mat[(i+1)%3][(j+2)%3] * mat[(i+2)%3][(j+1)%3];
                cof_reg[i][j]  <= vat_pkg::cof_t'(cpa_reg[i][j])
                                  - vat_pkg::cof_t'(cpb_reg[i][j]);
                // inverse transpose up to the positive factor 1/|det|
                ncof_reg[i][j] <= det_reg[vat_pkg::VW-1] ? -cof_reg[i][j] : cof_reg[i][j];
            end
        end
        for (int j = 0; j < 3; j++) begin
            dhi_reg[j]   <= $signed(cof_reg[0][j][64:32]) * mat[0][j];
            dlo_reg[j]   <= $signed({1'b0, cof_reg[0][j][31:0]}) * mat[0][j];
            dpart_reg[j] <= (vat_pkg::wide_t'(dhi_reg[j]) <<< 32)
                            + vat_pkg::wide_t'(dlo_reg[j]);
        end
        det_reg  <= dpart_reg[0] + dpart_reg[1] + dpart_reg[2];
        dabs_reg <= det_abs;
        sing_reg <= (det_abs <= vat_pkg::SING_LIMIT);
    end

    // ------------------------------------------------------------------
    // handshake: the whole pipeline advances unless the output is blocked
    // ------------------------------------------------------------------
    logic             vld_reg  [1:S_OUT];
    vat_pkg::req_t    mode_reg [1:S_OUT];

    assign ce      = !vld_reg[S_OUT] || m_ready;
    assign s_ready = ce && (settle_reg == 3'd0);
    assign accept  = s_valid && s_ready;
    assign m_valid = vld_reg[S_OUT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 1; k <= S_OUT; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else if (ce) begin
            vld_reg[1] <= accept;
            for (int k = 2; k <= S_OUT; k++) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // datapath registers
    // ------------------------------------------------------------------
    logic signed [31:0]     vin_reg [3];
    logic signed [64:0]     ph_reg  [3][3];
    logic signed [64:0]     pl_reg  [3][3];
    vat_pkg::wide_t         p_reg   [3][3];
    vat_pkg::wide_t         vec_reg [3];
    logic [2:0][vat_pkg::VW-1:0] mag_reg [S_ABS:S_LZ];
    logic [2:0]             neg_reg    [S_ABS:S_OUT-1];
    logic [2:0][31:0]       posres_reg [S_ABS:S_OUT-1];
    logic [vat_pkg::NCH-1:0] nz_reg;
    logic [3:0]             top_reg [vat_pkg::NCH];
    logic [6:0]             b_reg    [S_LZ:S_LEN];
    logic                   zero_reg [S_LZ:S_LEN];
    logic [2:0][29:0]       sc_reg   [S_SHF:S_LEN-1];
    logic [59:0]            sq_reg   [3];
    logic [61:0]            rad_reg;
    vat_pkg::rt_t           rt_reg   [S_RT0:S_LEN-1];
    logic [44:0]            y_reg;
    logic [vat_pkg::RT_BITS-1:0] len_reg [S_LEN:S_OUT-2];
    vat_pkg::dv_t           dv_reg   [3][S_DV0-1:S_OUT-1];
    logic                   degen_reg [S_DV0:S_OUT-1];
    logic [31:0]            out_reg  [3];
    logic                   fb_reg;

    // next values of the computed stages
    vat_pkg::cof_t          coef;
    logic signed [64:0]     ph_next [3][3];
    logic signed [64:0]     pl_next [3][3];
    vat_pkg::wide_t         vec_next [3];
    logic                   pos_sum;
    vat_pkg::wide_t         rnd;
    vat_pkg::wide_t         shr;
    logic [2:0][31:0]       posres_next;
    logic [2:0][vat_pkg::VW-1:0] mag_next;
    logic [vat_pkg::VW-1:0] or_all;
    logic [vat_pkg::NCH-1:0] nz_next;
    logic [3:0]             top_next [vat_pkg::NCH];
    logic [6:0]             b_next;
    logic [2:0][29:0]       sc_next;
    vat_pkg::rt_t           rt_next [vat_pkg::RT_N];
    vat_pkg::rt_t           rt_tmp;
    logic [vat_pkg::RT_BITS-1:0] len_w;
    vat_pkg::dv_t           dv_next [3][vat_pkg::DV_N];
    vat_pkg::dv_t           dv_tmp;
    logic [114:0]           len_sh;
    logic [vat_pkg::VW-1:0] thr;
    logic                   degen_next;
    logic [31:0]            qs;
    logic [31:0]            out_next [3];
    logic                   fb_next;
    logic                   fall_dir;
    logic                   fall_nrm;

    always_comb begin
        // coefficient products: matrix for position and direction, folded
        // cofactors for normals; split as signed high and unsigned low words
        for (int r = 0; r < 3; r++) begin
            for (int j = 0; j < 3; j++) begin
                coef = (mode_reg[S_IN] == vat_pkg::REQ_NRM) ? ncof_reg[r][j]
                                                            : vat_pkg::cof_t'(mat[r][j]);
                ph_next[r][j] = $signed(coef[64:32]) * vin_reg[j];
                pl_next[r][j] = $signed({1'b0, coef[31:0]}) * vin_reg[j];
            end
        end

        // row sums, translation only for position (reserved code too)
        pos_sum = (mode_reg[S_CMB] != vat_pkg::REQ_DIR) && (mode_reg[S_CMB] != vat_pkg::REQ_NRM);
        for (int r = 0; r < 3; r++) begin
            vec_next[r] = p_reg[r][0] + p_reg[r][1] + p_reg[r][2]
                          + (pos_sum ? (vat_pkg::wide_t'(tr[r]) <<< 16) : vat_pkg::wide_t'(0));
        end

        // magnitudes and rounded, saturated position result
        for (int r = 0; r < 3; r++) begin
            mag_next[r] = vec_reg[r][vat_pkg::VW-1] ? vat_pkg::VW'(-vec_reg[r])
                                                    : vat_pkg::VW'(vec_reg[r]);
            rnd = vec_reg[r] + vat_pkg::wide_t'(vat_pkg::RND_HALF);
            shr = rnd >>> 16;
            if (shr[vat_pkg::VW-1:31] == '0 || shr[vat_pkg::VW-1:31] == '1) begin
                posres_next[r] = shr[31:0];
            end else begin
                posres_next[r] = shr[vat_pkg::VW-1] ? vat_pkg::SAT_NEG : vat_pkg::SAT_POS;
            end
        end

        // leading one, first per chunk (the OR has the same top bit as the max)
        or_all = mag_reg[S_ABS][0] | mag_reg[S_ABS][1] | mag_reg[S_ABS][2];
        for (int c = 0; c < vat_pkg::NCH; c++) begin
            nz_next[c]  = |or_all[c*vat_pkg::CW +: vat_pkg::CW];
            top_next[c] = 4'd0;
            for (int t = 0; t < vat_pkg::CW; t++) begin
                if (or_all[c*vat_pkg::CW + t]) begin
                    top_next[c] = 4'(t);
                end
            end
        end

        // bit count of the largest magnitude
        b_next = 7'd0;
        for (int c = 0; c < vat_pkg::NCH; c++) begin
            if (nz_reg[c]) begin
                b_next = 7'(c * vat_pkg::CW) + 7'(top_reg[c]) + 7'd1;
            end
        end

        // scale so the largest magnitude lies in [2^29, 2^30)
        for (int r = 0; r < 3; r++) begin
            sc_next[r] = 30'({mag_reg[S_LZ][r], 30'd0} >> b_reg[S_LZ]);
        end

        // square root, two bits per stage
        rt_tmp.rem  = 64'(rad_reg);
        rt_tmp.root = '0;
        rt_tmp      = vat_pkg::rt_step(rt_tmp, vat_pkg::RT_BITS - 1);
        rt_tmp      = vat_pkg::rt_step(rt_tmp, vat_pkg::RT_BITS - 2);
        rt_next[0]  = rt_tmp;
        for (int q = 1; q < vat_pkg::RT_N; q++) begin
            rt_tmp = vat_pkg::rt_step(rt_reg[S_RT0+q-1], vat_pkg::RT_BITS - 1 - 2*q);
            if (vat_pkg::RT_BITS - 2 - 2*q >= 0) begin
                rt_tmp = vat_pkg::rt_step(rt_tmp, vat_pkg::RT_BITS - 2 - 2*q);
            end
            rt_next[q] = rt_tmp;
        end
        len_w = rt_reg[S_LEN-1].root;

        // divide stages, three lanes sharing the length
        for (int r = 0; r < 3; r++) begin
            for (int d = 0; d < vat_pkg::DV_N; d++) begin
                dv_tmp = vat_pkg::dv_step(dv_reg[r][S_DV0-1+d], len_reg[S_LEN+d],
                                          vat_pkg::QB - 1 - 2*d);
                if (vat_pkg::QB - 2 - 2*d >= 0) begin
                    dv_tmp = vat_pkg::dv_step(dv_tmp, len_reg[S_LEN+d],
                                              vat_pkg::QB - 2 - 2*d);
                end
                dv_next[r][d] = dv_tmp;
            end
        end

        // short length test: len*10000 rescaled against the threshold
        len_sh     = {y_reg, 70'd0} >> (7'(vat_pkg::VW) - b_reg[S_LEN]);
        thr        = (mode_reg[S_LEN] == vat_pkg::REQ_NRM) ? dabs_reg : vat_pkg::DIR_THR;
        degen_next = zero_reg[S_LEN] || (len_reg[S_LEN] == '0) || (len_sh <= 115'(thr));

        // final select
        for (int r = 0; r < 3; r++) begin
            qs          = 32'(dv_reg[r][S_OUT-1].quo);
            out_next[r] = neg_reg[S_OUT-1][r] ? (32'd0 - qs) : qs;
        end
        fall_dir = degen_reg[S_OUT-1];
        fall_nrm = sing_reg || degen_reg[S_OUT-1];
        fb_next  = 1'b0;
        case (mode_reg[S_OUT-1])
            vat_pkg::REQ_DIR: begin
                if (fall_dir) begin
                    out_next[0] = vat_pkg::Q_ONE;
                    out_next[1] = '0;
                    out_next[2] = '0;
                    fb_next     = 1'b1;
                end
            end
            vat_pkg::REQ_NRM: begin
                if (fall_nrm) begin
                    out_next[0] = '0;
                    out_next[1] = vat_pkg::Q_ONE;
                    out_next[2] = '0;
                    fb_next     = 1'b1;
                end
            end
            default: begin
                for (int r = 0; r < 3; r++) begin
                    out_next[r] = posres_reg[S_OUT-1][r];
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            // input capture
            mode_reg[S_IN] <= vat_pkg::req_t'(s_req_type);
            vin_reg[0]     <= s_in_x;
            vin_reg[1]     <= s_in_y;
            vin_reg[2]     <= s_in_z;
            for (int k = 2; k <= S_OUT; k++) begin
                mode_reg[k] <= mode_reg[k-1];
            end

            // products and row sums
            for (int r = 0; r < 3; r++) begin
                for (int j = 0; j < 3; j++) begin
                    ph_reg[r][j] <= ph_next[r][j];
                    pl_reg[r][j] <= pl_next[r][j];
                    p_reg[r][j]  <= (vat_pkg::wide_t'(ph_reg[r][j]) <<< 32)
                                    + vat_pkg::wide_t'(pl_reg[r][j]);
                end
                vec_reg[r] <= vec_next[r];
            end

            // magnitudes, signs, position result
            mag_reg[S_ABS]    <= mag_next;
            mag_reg[S_CHK]    <= mag_reg[S_ABS];
            mag_reg[S_LZ]     <= mag_reg[S_CHK];
            neg_reg[S_ABS]    <= {vec_reg[2][vat_pkg::VW-1], vec_reg[1][vat_pkg::VW-1],
                                  vec_reg[0][vat_pkg::VW-1]};
            posres_reg[S_ABS] <= posres_next;
            for (int k = S_ABS + 1; k <= S_OUT - 1; k++) begin
                neg_reg[k]    <= neg_reg[k-1];
                posres_reg[k] <= posres_reg[k-1];
            end

            // normalization front end
            nz_reg <= nz_next;
            for (int c = 0; c < vat_pkg::NCH; c++) begin
                top_reg[c] <= top_next[c];
            end
            b_reg[S_LZ]    <= b_next;
            zero_reg[S_LZ] <= ~|nz_reg;
            for (int k = S_LZ + 1; k <= S_LEN; k++) begin
                b_reg[k]    <= b_reg[k-1];
                zero_reg[k] <= zero_reg[k-1];
            end
            sc_reg[S_SHF] <= sc_next;
            for (int k = S_SHF + 1; k <= S_LEN - 1; k++) begin
                sc_reg[k] <= sc_reg[k-1];
            end
            for (int r = 0; r < 3; r++) begin
                sq_reg[r] <= sc_reg[S_SHF][r] * sc_reg[S_SHF][r];
            end
            rad_reg <= 62'(sq_reg[0]) + 62'(sq_reg[1]) + 62'(sq_reg[2]);

            // square root
            for (int q = 0; q < vat_pkg::RT_N; q++) begin
                rt_reg[S_RT0+q] <= rt_next[q];
            end

            // length scaling and dividends
            y_reg          <= 45'(len_w) * 45'(vat_pkg::LEN_SCALE);
            len_reg[S_LEN] <= len_w;
            for (int k = S_LEN + 1; k <= S_OUT - 2; k++) begin
                len_reg[k] <= len_reg[k-1];
            end
            for (int r = 0; r < 3; r++) begin
                dv_reg[r][S_DV0-1].rem <= 48'({sc_reg[S_LEN-1][r], 16'd0})
                                          + 48'(len_w >> 1);
                dv_reg[r][S_DV0-1].quo <= '0;
                for (int d = 0; d < vat_pkg::DV_N; d++) begin
                    dv_reg[r][S_DV0+d] <= dv_next[r][d];
                end
            end

            // fallback test, then output
            degen_reg[S_DV0] <= degen_next;
            for (int k = S_DV0 + 1; k <= S_OUT - 1; k++) begin
                degen_reg[k] <= degen_reg[k-1];
            end
            for (int r = 0; r < 3; r++) begin
                out_reg[r] <= out_next[r];
            end
            fb_reg <= fb_next;
        end
    end

    assign m_out_x         = out_reg[0];
    assign m_out_y         = out_reg[1];
    assign m_out_z         = out_reg[2];
    assign m_fallback_used = fb_reg;

endmodule
